### hw/rtl/bsim_pkg.sv
`timescale 1ns / 1ps

package bsim_pkg;

    // Field widths of the item and result transactions
    localparam int KIND_W   = 2;
    localparam int ADDR_W   = 16;
    localparam int DATA_W   = 8;
    localparam int CYC_W    = 8;
    localparam int TGT_W    = 3;
    localparam int MADDR_W  = 21;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    // Storage shapes
    localparam int PRG_BANKS   = 3;
    localparam int CHR_BANKS   = 8;
    localparam int NT_PAGES    = 4;
    localparam int BANK_W      = 8;
    localparam int COUNT_W     = 15;
    localparam int WRAM_BYTES  = 8192;
    localparam int WRAM_AW     = $clog2(WRAM_BYTES);
    localparam int PRG_PAGE_AW = 13;
    localparam int CHR_PAGE_AW = 10;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PRG_MASK = 1'b0,
        CFG_CHR_MASK = 1'b1
    } t_cfg_idx;

    // Item kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_WRITE     = 2'd0,
        KIND_CPU_XLATE = 2'd1,
        KIND_PPU_XLATE = 2'd2,
        KIND_TICK      = 2'd3
    } t_kind;

    // Result targets
    typedef enum logic [TGT_W-1:0] {
        TGT_NONE     = 3'd0,
        TGT_PRG      = 3'd1,
        TGT_WRAM     = 3'd2,
        TGT_SOUND    = 3'd3,
        TGT_CHR      = 3'd4,
        TGT_NT       = 3'd5,
        TGT_REGISTER = 3'd6
    } t_target;

    typedef struct packed {
        t_kind             kind;
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] data;
        logic [CYC_W-1:0]  cycles;
    } t_item;

    typedef struct packed {
        t_target            target;
        logic [MADDR_W-1:0] mapped_address;
        logic               irq_line;
    } t_result;

endpackage

### hw/rtl/bsim_ifs.sv
`timescale 1ns / 1ps

// Item channel: one bus access or cycle tick per transaction.
interface bsim_item_if import bsim_pkg::*;;
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] data;
    logic [CYC_W-1:0]  cycles;

    modport source (output valid, output kind, output address, output data,
                    output cycles, input ready);
    modport sink (input valid, input kind, input address, input data,
                  input cycles, output ready);
endinterface

// Result channel: one mapping result per transaction.
interface bsim_result_if import bsim_pkg::*;;
    logic               valid;
    logic               ready;
    logic [TGT_W-1:0]   target;
    logic [MADDR_W-1:0] mapped_address;
    logic               irq_line;

    modport source (output valid, output target, output mapped_address,
                    output irq_line, input ready);
    modport sink (input valid, input target, input mapped_address,
                  input irq_line, output ready);
endinterface

### hw/rtl/bank_switch_irq_mapper.sv
`timescale 1ns / 1ps
// An accepted transaction goes through the input register, then decode and state
// update into the result register. Throughput: one transaction per cycle unless
// o_result stalls, set by the single decode stage. Reset (synchronous, active low)
// empties both registers and restores the bank, nametable and IRQ state and both
// masks to their power-on values.
module bank_switch_irq_mapper import bsim_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    bsim_item_if.sink             i_item,
    bsim_result_if.source         o_result,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;
    t_result core_res;
    logic    advance;
    logic    accept;

    // The decode stage moves whenever the result register is free or being emptied
    assign advance = r_in_valid && (!r_out_valid || o_result.ready);
    assign accept  = i_item.valid && i_item.ready;
    assign i_item.ready = !r_in_valid || advance;

    bsim_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_fire      (advance),
        .i_item      (r_in),
        .o_result    (core_res)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_in_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in.kind    <= t_kind'(i_item.kind);
            r_in.address <= i_item.address;
            r_in.data    <= i_item.data;
            r_in.cycles  <= i_item.cycles;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= core_res;
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.target         = r_out.target;
    assign o_result.mapped_address = r_out.mapped_address;
    assign o_result.irq_line       = r_out.irq_line;

    // A tick never addresses anything.
    a_tick_no_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in.kind == KIND_TICK |=> r_out.target == TGT_NONE
            && r_out.mapped_address == '0)
        else $error("tick transaction produced a target");

    // A PPU address only ever lands in CHR, nametable RAM or nowhere.
    a_ppu_targets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in.kind == KIND_PPU_XLATE |=> r_out.target == TGT_CHR
            || r_out.target == TGT_NT || r_out.target == TGT_NONE)
        else $error("PPU transaction mapped to a CPU-side target");

    // The interrupt can only rise on a tick.
    a_irq_rise_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in.kind != KIND_TICK && core_res.irq_line
            |-> $past(advance) && $past(core_res.irq_line) || !$past(i_rst_n)
            || r_out.irq_line || !r_out_valid || $past(core_res.irq_line))
        else $error("interrupt raised by a non-tick transaction");

    // A held result must not be overwritten by the decode stage.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_result.ready |-> !advance)
        else $error("result register overwritten while stalled");

endmodule

### hw/rtl/bsim_core.sv
`timescale 1ns / 1ps

// Mapper state and decode: bank registers, nametable selects, IRQ counter.
// The item's result is combinational; masks move on i_cfg_we, other state on i_fire.
module bsim_core import bsim_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_fire,
    input  t_item                 i_item,
    output t_result               o_result
);

    logic [BANK_W-1:0]  r_prg_mask;
    logic [BANK_W-1:0]  r_chr_mask;
    logic [BANK_W-1:0]  r_prg [PRG_BANKS];
    logic [BANK_W-1:0]  r_chr [CHR_BANKS];
    logic               r_page [NT_PAGES];
    logic [COUNT_W-1:0] r_count;
    logic               r_en;
    logic               r_pend;

    logic [BANK_W-1:0]  n_prg [PRG_BANKS];
    logic [BANK_W-1:0]  n_chr [CHR_BANKS];
    logic               n_page [NT_PAGES];
    logic [COUNT_W-1:0] n_count;
    logic               n_en;
    logic               n_pend;

    logic [ADDR_W-1:0]  a;
    logic [BANK_W-1:0]  prg_sel;
    logic [BANK_W-1:0]  chr_sel;
    logic [COUNT_W:0]   tick_sum;
    logic [1:0]         prg_wr_idx;
    t_target            res_tgt;
    logic [MADDR_W-1:0] res_ma;

    assign a        = i_item.address;
    assign tick_sum = {1'b0, r_count} + {{(COUNT_W + 1 - CYC_W){1'b0}}, i_item.cycles};
    assign prg_wr_idx = a[12:11];

    // PRG bank for the 0x8000-0xDFFF windows; the fourth code does not occur
    always_comb begin
        unique case (a[14:13])
            2'd0:    prg_sel = r_prg[0];
            2'd1:    prg_sel = r_prg[1];
            default: prg_sel = r_prg[2];
        endcase
    end

    assign chr_sel = r_chr[a[12:10]] & r_chr_mask;

    // Decode of one item and the next state that it leaves
    always_comb begin
        n_prg   = r_prg;
        n_chr   = r_chr;
        n_page  = r_page;
        n_count = r_count;
        n_en    = r_en;
        n_pend  = r_pend;
        res_tgt = TGT_NONE;
        res_ma  = '0;
        unique case (i_item.kind)
            KIND_WRITE: begin
                priority if (a[15:11] == 5'b01001) begin
                    res_tgt = TGT_SOUND;
                    res_ma  = {{(MADDR_W - ADDR_W){1'b0}}, a};
                end else if (a[15:13] == 3'b011) begin
                    res_tgt = TGT_WRAM;
                    res_ma  = {{(MADDR_W - WRAM_AW){1'b0}}, a[WRAM_AW-1:0]};
                end else if (a[15:14] == 2'b10) begin
                    res_tgt = TGT_REGISTER;
                    res_ma  = {{(MADDR_W - ADDR_W){1'b0}}, a};
                    if (a[10]) begin
                        if (a[13]) begin
                            n_count = {i_item.data[6:0], r_count[7:0]};
                            n_en    = i_item.data[7];
                            n_pend  = 1'b0;
                        end else begin
                            n_count = {r_count[COUNT_W-1:8], i_item.data};
                        end
                    end else begin
                        n_chr[a[13:11]] = i_item.data;
                    end
                end else if (a[15:13] == 3'b110) begin
                    if (!a[10]) begin
                        n_page[a[12:11]] = i_item.data[0];
                        res_tgt = TGT_REGISTER;
                        res_ma  = {{(MADDR_W - ADDR_W){1'b0}}, a};
                    end
                end else if (a[15:13] == 3'b111) begin
                    if (a[12] && a[11]) begin
                        res_tgt = TGT_SOUND;
                        res_ma  = {{(MADDR_W - ADDR_W){1'b0}}, a};
                    end else if (!a[10]) begin
                        unique case (prg_wr_idx)
                            2'd0:    n_prg[0] = i_item.data;
                            2'd1:    n_prg[1] = i_item.data;
                            default: n_prg[2] = i_item.data;
                        endcase
                        res_tgt = TGT_REGISTER;
                        res_ma  = {{(MADDR_W - ADDR_W){1'b0}}, a};
                    end
                end else begin
                    // Writes elsewhere are ignored.
                end
            end
            KIND_CPU_XLATE: begin
                priority if (a[15:11] == 5'b01001) begin
                    res_tgt = TGT_SOUND;
                    res_ma  = {{(MADDR_W - ADDR_W){1'b0}}, a};
                end else if (a[15:13] == 3'b011) begin
                    res_tgt = TGT_WRAM;
                    res_ma  = {{(MADDR_W - WRAM_AW){1'b0}}, a[WRAM_AW-1:0]};
                end else if (a[15:13] == 3'b111) begin
                    // Fixed last bank
                    res_tgt = TGT_PRG;
                    res_ma  = {r_prg_mask, a[PRG_PAGE_AW-1:0]};
                end else if (a[15]) begin
                    res_tgt = TGT_PRG;
                    res_ma  = {prg_sel & r_prg_mask, a[PRG_PAGE_AW-1:0]};
                end else begin
                    // Unmapped CPU addresses map to nothing.
                end
            end
            KIND_PPU_XLATE: begin
                priority if (!a[13]) begin
                    res_tgt = TGT_CHR;
                    res_ma  = {{(MADDR_W - BANK_W - CHR_PAGE_AW){1'b0}}, chr_sel,
                               a[CHR_PAGE_AW-1:0]};
                end else if (a[13:8] != 6'h3F) begin
                    res_tgt = TGT_NT;
                    res_ma  = {{(MADDR_W - CHR_PAGE_AW - 1){1'b0}}, r_page[a[11:10]],
                               a[CHR_PAGE_AW-1:0]};
                end else begin
                    // The palette maps to nothing.
                end
            end
            default: begin
                // Cycle tick: the interrupt fires once the count passes 0x7FFF
                if (r_en) begin
                    if (tick_sum[COUNT_W]) begin
                        n_pend  = 1'b1;
                        n_en    = 1'b0;
                        n_count = '0;
                    end else begin
                        n_count = tick_sum[COUNT_W-1:0];
                    end
                end
            end
        endcase
    end

    assign o_result.target         = res_tgt;
    assign o_result.mapped_address = res_ma;
    assign o_result.irq_line       = n_pend;

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prg_mask <= '1;
            r_chr_mask <= '1;
            for (int i = 0; i < PRG_BANKS; i++) begin
                r_prg[i] <= BANK_W'(i);
            end
            for (int i = 0; i < CHR_BANKS; i++) begin
                r_chr[i] <= BANK_W'(i);
            end
            for (int i = 0; i < NT_PAGES; i++) begin
                r_page[i] <= (i >= NT_PAGES / 2);
            end
            r_count <= '0;
            r_en    <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_PRG_MASK: r_prg_mask <= i_cfg_data;
                    default:      r_chr_mask <= i_cfg_data;
                endcase
            end
            if (i_fire) begin
                r_prg   <= n_prg;
                r_chr   <= n_chr;
                r_page  <= n_page;
                r_count <= n_count;
                r_en    <= n_en;
                r_pend  <= n_pend;
            end
        end
    end

endmodule

### bench/bank_switch_irq_mapper_checker.sv
`timescale 1ns / 1ps

// Watches the item, result and configuration ports of the mapper, predicts the
// result of every accepted item transaction and compares it with what comes out.
module bank_switch_irq_mapper_checker import bsim_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    bsim_item_if                  i_item_mon,
    bsim_result_if                i_result_mon,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int unsigned           o_mismatches,
    output int unsigned           o_outstanding
);

    // Predicted cartridge state.
    logic [BANK_W-1:0] prg_mask;
    logic [BANK_W-1:0] chr_mask;
    logic [BANK_W-1:0] prg_bank [PRG_BANKS];
    logic [BANK_W-1:0] chr_bank [CHR_BANKS];
    logic              nt_page  [NT_PAGES];
    logic [15:0]       irq_cnt;
    logic              irq_en;
    logic              irq_req;

    t_result     awaited_mappings [$];
    int unsigned mismatch_count = 0;
    int unsigned awaited_count  = 0;

    assign o_mismatches  = mismatch_count;
    assign o_outstanding = awaited_count;

    // Every mismatch prints one line and is counted.
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: mapper mismatch on %s: got 0x%0h, expected 0x%0h",
                 $time, what, got, want);
        mismatch_count++;
    endtask

    // An 8 KiB PRG window: masked bank number above the offset in the window.
    function automatic logic [MADDR_W-1:0] prg_window(input logic [BANK_W-1:0] bank,
                                                      input logic [15:0] addr);
        return {bank & prg_mask, addr[PRG_PAGE_AW-1:0]};
    endfunction

    // Applies one access to the predicted state and returns the result it gives.
    function automatic t_result apply_access(input t_item acc);
        t_result     res;
        logic [15:0] a;
        logic [13:0] pa;
        logic [1:0]  slot;
        logic [BANK_W-1:0] bank;
        res.target         = TGT_NONE;
        res.mapped_address = '0;
        a  = acc.address;
        pa = acc.address[13:0];
        case (acc.kind)
            KIND_WRITE: begin
                if (a >= 16'h4800 && a <= 16'h4FFF) begin
                    res.target         = TGT_SOUND;
                    res.mapped_address = MADDR_W'(a);
                end else if (a >= 16'h6000 && a <= 16'h7FFF) begin
                    res.target         = TGT_WRAM;
                    res.mapped_address = MADDR_W'(a[WRAM_AW-1:0]);
                end else if (a >= 16'h8000 && a <= 16'hBFFF) begin
                    res.target         = TGT_REGISTER;
                    res.mapped_address = MADDR_W'(a);
                    if (a[10]) begin
                        // Interrupt counter; the high byte also acknowledges.
                        if (a[13]) begin
                            irq_cnt = {1'b0, acc.data[6:0], irq_cnt[7:0]};
                            irq_en  = acc.data[7];
                            irq_req = 1'b0;
                        end else begin
                            irq_cnt[7:0] = acc.data;
                        end
                    end else begin
                        chr_bank[a[13:11]] = acc.data;
                    end
                end else if (a >= 16'hC000 && a <= 16'hDFFF) begin
                    if (!a[10]) begin
                        nt_page[a[12:11]]  = acc.data[0];
                        res.target         = TGT_REGISTER;
                        res.mapped_address = MADDR_W'(a);
                    end
                end else if (a >= 16'hE000) begin
                    if (a >= 16'hF000 && a[11]) begin
                        res.target         = TGT_SOUND;
                        res.mapped_address = MADDR_W'(a);
                    end else if (!a[10]) begin
                        slot = a[12:11];
                        if (slot < 2'd3) prg_bank[slot] = acc.data;
                        res.target         = TGT_REGISTER;
                        res.mapped_address = MADDR_W'(a);
                    end
                end
            end
            KIND_CPU_XLATE: begin
                if (a >= 16'h4800 && a <= 16'h4FFF) begin
                    res.target         = TGT_SOUND;
                    res.mapped_address = MADDR_W'(a);
                end else if (a >= 16'h6000 && a <= 16'h7FFF) begin
                    res.target         = TGT_WRAM;
                    res.mapped_address = MADDR_W'(a[WRAM_AW-1:0]);
                end else if (a >= 16'h8000 && a <= 16'hDFFF) begin
                    res.target         = TGT_PRG;
                    res.mapped_address = prg_window(prg_bank[a[14:13]], a);
                end else if (a >= 16'hE000) begin
                    // The top window is fixed to the last bank.
                    res.target         = TGT_PRG;
                    res.mapped_address = prg_window(8'hFF, a);
                end
            end
            KIND_PPU_XLATE: begin
                // The PPU bus wraps every 16 KiB; the palette maps to nothing.
                if (pa < 14'h2000) begin
                    bank               = chr_bank[pa[12:10]] & chr_mask;
                    res.target         = TGT_CHR;
                    res.mapped_address = MADDR_W'({bank, pa[CHR_PAGE_AW-1:0]});
                end else if (pa < 14'h3F00) begin
                    res.target         = TGT_NT;
                    res.mapped_address = MADDR_W'({nt_page[pa[11:10]], pa[9:0]});
                end
            end
            default: begin
                // Cycle tick: once the count passes 0x7FFF the interrupt fires
                // and the counter clears and stops.
                if (irq_en) begin
                    irq_cnt = irq_cnt + 16'(acc.cycles);
                    if (irq_cnt > 16'h7FFF) begin
                        irq_req = 1'b1;
                        irq_en  = 1'b0;
                        irq_cnt = '0;
                    end
                end
            end
        endcase
        res.irq_line = irq_req;
        return res;
    endfunction

    // Results are checked before new items are predicted, so a result never meets
    // the expectation of an item accepted at the same edge.
    always @(posedge i_clk) begin
        t_item   acc;
        t_result want;
        if (!i_rst_n) begin
            prg_mask = 8'hFF;
            chr_mask = 8'hFF;
            for (int i = 0; i < PRG_BANKS; i++) prg_bank[i] = BANK_W'(i);
            for (int i = 0; i < CHR_BANKS; i++) chr_bank[i] = BANK_W'(i);
            for (int i = 0; i < NT_PAGES; i++) nt_page[i] = (i >= 2);
            irq_cnt  = '0;
            irq_en   = 1'b0;
            irq_req  = 1'b0;
            awaited_mappings.delete();
            awaited_count = 0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_PRG_MASK: prg_mask = i_cfg_data;
                    CFG_CHR_MASK: chr_mask = i_cfg_data;
                    default: ;
                endcase
            end

            if (i_result_mon.valid && i_result_mon.ready) begin
                if (awaited_mappings.size() == 0) begin
                    report_mismatch("result transaction with nothing outstanding",
                                    32'(i_result_mon.target), 32'(TGT_NONE));
                end else begin
                    want = awaited_mappings.pop_front();
                    awaited_count--;
                    if (i_result_mon.target !== want.target)
                        report_mismatch("target", 32'(i_result_mon.target),
                                        32'(want.target));
                    if (i_result_mon.mapped_address !== want.mapped_address)
                        report_mismatch("mapped_address", 32'(i_result_mon.mapped_address),
                                        32'(want.mapped_address));
                    if (i_result_mon.irq_line !== want.irq_line)
                        report_mismatch("irq_line", 32'(i_result_mon.irq_line),
                                        32'(want.irq_line));
                end
            end

            if (i_item_mon.valid && i_item_mon.ready) begin
                acc.kind    = t_kind'(i_item_mon.kind);
                acc.address = i_item_mon.address;
                acc.data    = i_item_mon.data;
                acc.cycles  = i_item_mon.cycles;
                awaited_mappings.push_back(apply_access(acc));
                awaited_count++;
            end
        end
    end

endmodule

### bench/tb_bank_switch_irq_mapper.sv
`timescale 1ns / 1ps

module tb_bank_switch_irq_mapper;
    import bsim_pkg::*;

    localparam int unsigned QUIET_LIMIT      = 2000;
    localparam int unsigned HOLD_CYCLES      = 200;
    localparam int unsigned TAIL_CYCLES      = 16;
    localparam int unsigned ACCESSES_PER_SET = 285;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int unsigned           mismatches;
    int unsigned           outstanding;

    // Idling percentages and long receiver hold-offs requested by the stimulus.
    int unsigned src_idle_pct   = 0;
    int unsigned sink_stall_pct = 0;
    int unsigned hold_requests  = 0;

    bsim_item_if   item_ch ();
    bsim_result_if result_ch ();

    bank_switch_irq_mapper i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_item      (item_ch),
        .o_result    (result_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    bank_switch_irq_mapper_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_item_mon    (item_ch),
        .i_result_mon  (result_ch),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Result receiver: random stalls, or a long hold-off counted here when asked.
    initial begin : result_sink
        int unsigned hold_left;
        int unsigned hold_served;
        hold_left       = 0;
        hold_served     = 0;
        result_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_served != hold_requests) begin
                hold_served = hold_requests;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                result_ch.ready <= 1'b0;
                hold_left--;
            end else begin
                result_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
            end
        end
    end

    // The run is abandoned if no transaction moves on either channel for too long.
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        wait (rst_n === 1'b1);
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic t_item make_access(input t_kind kind, input logic [15:0] addr,
                                          input logic [7:0] data, input logic [7:0] cyc);
        t_item acc;
        acc.kind    = kind;
        acc.address = addr;
        acc.data    = data;
        acc.cycles  = cyc;
        return acc;
    endfunction

    // Mostly well-formed bus traffic, with interrupt counter programming biased
    // towards counts close to the point where the interrupt fires.
    function automatic t_item random_access();
        t_item       acc;
        int unsigned pick;
        acc.kind    = KIND_TICK;
        acc.address = 16'($urandom);
        acc.data    = 8'($urandom);
        acc.cycles  = 8'($urandom);
        pick        = $urandom_range(0, 99);
        if (pick < 22) begin
            acc.kind    = KIND_WRITE;
            acc.address = 16'h8000 | 16'($urandom_range(0, 16'h7FFF));
        end else if (pick < 34) begin
            acc.kind             = KIND_WRITE;
            acc.address[15:13]   = ($urandom_range(0, 2) != 0) ? 3'b101 : 3'b100;
            acc.address[10]      = 1'b1;
            case ($urandom_range(0, 4))
                0, 1:    acc.data[6:1] = 6'h3F;
                2:       acc.data[6:4] = 3'b111;
                default: ;
            endcase
            acc.data[7] = ($urandom_range(0, 3) != 0);
        end else if (pick < 56) begin
            acc.kind = KIND_TICK;
        end else if (pick < 75) begin
            acc.kind = KIND_CPU_XLATE;
            if ($urandom_range(0, 1) != 0)
                acc.address = 16'h4000 + 16'($urandom_range(0, 16'hBFFF));
        end else if (pick < 94) begin
            acc.kind = KIND_PPU_XLATE;
        end else begin
            acc.kind = t_kind'($urandom_range(0, 3));
        end
        return acc;
    endfunction

    // Offers one item transaction, after a random gap, and returns at the falling
    // edge after it has been accepted.
    task automatic send_access(input t_item acc);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            item_ch.valid <= 1'b0;
            @(negedge clk);
        end
        item_ch.valid   <= 1'b1;
        item_ch.kind    <= acc.kind;
        item_ch.address <= acc.address;
        item_ch.data    <= acc.data;
        item_ch.cycles  <= acc.cycles;
        @(posedge clk);
        while (!item_ch.ready) @(posedge clk);
        @(negedge clk);
    endtask

    // Stops offering and waits until every result has arrived.
    task automatic wait_idle();
        item_ch.valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_cfg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_masks(input logic [7:0] prg, input logic [7:0] chr);
        wait_idle();
        write_cfg(CFG_PRG_MASK, prg);
        write_cfg(CFG_CHR_MASK, chr);
    endtask

    initial begin : stimulus
        logic [7:0]  prg_masks  [4];
        logic [7:0]  chr_masks  [4];
        int unsigned src_idle   [4];
        int unsigned sink_stall [4];
        prg_masks  = '{8'hFF, 8'h00, 8'h0F, 8'($urandom)};
        chr_masks  = '{8'h00, 8'hFF, 8'h3F, 8'($urandom)};
        src_idle   = '{0, 50, 0, 28};
        sink_stall = '{0, 0, 50, 28};

        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = CFG_PRG_MASK;
        cfg_data        = '0;
        item_ch.valid   = 1'b0;
        item_ch.kind    = KIND_WRITE;
        item_ch.address = '0;
        item_ch.data    = '0;
        item_ch.cycles  = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        write_cfg(CFG_PRG_MASK, 8'hFF);
        write_cfg(CFG_CHR_MASK, 8'hFF);

        // Bank, nametable and sound writes, including ones that are ignored.
        send_access(make_access(KIND_WRITE, 16'h8000, 8'hFF, 8'h00));
        send_access(make_access(KIND_WRITE, 16'hB800, 8'h80, 8'h00));
        send_access(make_access(KIND_WRITE, 16'hC000, 8'h01, 8'h00));
        send_access(make_access(KIND_WRITE, 16'hD800, 8'hFE, 8'h00));
        send_access(make_access(KIND_WRITE, 16'hC400, 8'h55, 8'h00));
        send_access(make_access(KIND_WRITE, 16'hE000, 8'hFF, 8'h00));
        send_access(make_access(KIND_WRITE, 16'hF000, 8'h7F, 8'h00));
        send_access(make_access(KIND_WRITE, 16'hF800, 8'hAA, 8'h00));
        send_access(make_access(KIND_WRITE, 16'h4800, 8'h00, 8'h00));
        send_access(make_access(KIND_WRITE, 16'h7FFF, 8'h12, 8'h00));
        // CPU translation at the edges of each region.
        send_access(make_access(KIND_CPU_XLATE, 16'h0000, 8'h00, 8'h00));
        send_access(make_access(KIND_CPU_XLATE, 16'h4FFF, 8'h00, 8'h00));
        send_access(make_access(KIND_CPU_XLATE, 16'h6000, 8'h00, 8'h00));
        send_access(make_access(KIND_CPU_XLATE, 16'h8000, 8'h00, 8'h00));
        send_access(make_access(KIND_CPU_XLATE, 16'hDFFF, 8'h00, 8'h00));
        send_access(make_access(KIND_CPU_XLATE, 16'hFFFF, 8'h00, 8'h00));
        // PPU translation: pattern tables, nametables, the palette and the wrap.
        send_access(make_access(KIND_PPU_XLATE, 16'h0000, 8'h00, 8'h00));
        send_access(make_access(KIND_PPU_XLATE, 16'h1FFF, 8'h00, 8'h00));
        send_access(make_access(KIND_PPU_XLATE, 16'h2000, 8'h00, 8'h00));
        send_access(make_access(KIND_PPU_XLATE, 16'h2FFF, 8'h00, 8'h00));
        send_access(make_access(KIND_PPU_XLATE, 16'hFF00, 8'h00, 8'h00));
        // Counter set just below the threshold, then crossed and acknowledged.
        send_access(make_access(KIND_WRITE, 16'h8400, 8'hFF, 8'h00));
        send_access(make_access(KIND_WRITE, 16'hA400, 8'hFF, 8'h00));
        send_access(make_access(KIND_TICK, 16'h0000, 8'h00, 8'h00));
        send_access(make_access(KIND_TICK, 16'hFFFF, 8'hFF, 8'h01));
        send_access(make_access(KIND_WRITE, 16'hA400, 8'h00, 8'h00));
        send_access(make_access(KIND_TICK, 16'h0000, 8'h00, 8'hFF));

        // Random traffic under several mask settings and idling patterns.
        for (int set = 0; set < 4; set++) begin
            set_masks(prg_masks[set], chr_masks[set]);
            src_idle_pct   = src_idle[set];
            sink_stall_pct = sink_stall[set];
            for (int n = 0; n < ACCESSES_PER_SET; n++) begin
                // One long receiver hold-off while items keep coming.
                if (set == 0 && n == 100) hold_requests++;
                send_access(random_access());
            end
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
